// ===== hw/rtl/crs_pkg.sv =====
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants of the controller remap scaler
// Field widths of the event channels, the packed mapping slot layout and
// the reset contents of the slot registers.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int ChannelWidth = 5;
  localparam int CcWidth      = 7;
  localparam int ValueWidth   = 7;
  localparam int OffsetWidth  = 16;
  localparam int SlotIdxWidth = 3;

  // Register file of the configuration port.
  localparam int SlotStore     = 8;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 38;

  // Arithmetic constants of the scaler.
  localparam logic [ValueWidth-1:0]   RoundBias  = 7'd63;
  localparam logic [ValueWidth:0]     ScaleDiv   = 8'd127;
  localparam logic [ValueWidth-1:0]   ValueMax   = 7'd127;
  localparam logic [ChannelWidth-1:0] ChannelMax = 5'd16;
  localparam logic [CcWidth-1:0]      OutCcBase  = 7'd20;

  // Packed slot layout, MSB first.
  typedef struct packed {
    logic [ValueWidth-1:0]   max_val;
    logic [ValueWidth-1:0]   min_val;
    logic [CcWidth-1:0]      out_cc;
    logic [3:0]              out_chan;   // output channel minus one
    logic [CcWidth-1:0]      in_cc;
    logic [ChannelWidth-1:0] in_chan;    // zero matches any channel
    logic                    enable;
  } slot_t;

  function automatic slot_t slot_reset(input logic [CfgIndexWidth-1:0] idx);
    slot_t s;
    s.max_val  = ValueMax;
    s.min_val  = '0;
    s.out_cc   = OutCcBase + CcWidth'(idx);
    s.out_chan = 4'(idx);
    s.in_cc    = CcWidth'(idx);
    s.in_chan  = '0;
    s.enable   = 1'b0;
    return s;
  endfunction

endpackage

// ===== hw/rtl/crs_in_if.sv =====
// ----------------------------------------------------------------------------
// crs_in_if: incoming control-change channel
// Valid/ready channel that carries one control-change event.
// ----------------------------------------------------------------------------
interface crs_in_if;
  logic                                valid;
  logic                                ready;
  logic [crs_pkg::ChannelWidth-1:0]    in_channel;
  logic [crs_pkg::CcWidth-1:0]         in_controller;
  logic [crs_pkg::ValueWidth-1:0]      in_value;
  logic [crs_pkg::OffsetWidth-1:0]     in_sample_offset;

  modport source (
    output valid, in_channel, in_controller, in_value, in_sample_offset,
    input  ready
  );

  modport sink (
    input  valid, in_channel, in_controller, in_value, in_sample_offset,
    output ready
  );
endinterface

// ===== hw/rtl/crs_out_if.sv =====
// ----------------------------------------------------------------------------
// crs_out_if: remapped control-change channel
// Valid/ready channel that carries one remapped control change.
// ----------------------------------------------------------------------------
interface crs_out_if;
  logic                                valid;
  logic                                ready;
  logic [crs_pkg::ChannelWidth-1:0]    out_channel;
  logic [crs_pkg::CcWidth-1:0]         out_controller;
  logic [crs_pkg::ValueWidth-1:0]      out_value;
  logic [crs_pkg::OffsetWidth-1:0]     out_sample_offset;
  logic [crs_pkg::SlotIdxWidth-1:0]    slot_index;
  logic                                last_of_run;

  modport source (
    output valid, out_channel, out_controller, out_value, out_sample_offset,
           slot_index, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, out_channel, out_controller, out_value, out_sample_offset,
           slot_index, last_of_run,
    output ready
  );
endinterface

// ===== hw/rtl/controller_remap_scaler.sv =====
// ----------------------------------------------------------------------------
// controller_remap_scaler: control-change remapper with per-slot scaling
// Matches each incoming control change against the mapping slots and emits
// one remapped, range-scaled control change per matching slot.
// ----------------------------------------------------------------------------
// Usage:
//   cc_in carries incoming control-change transactions, cc_out carries the
//   remapped ones; both are valid/ready channels. The mapping slots are
//   written through cfg_write/cfg_index/cfg_data; the user must write them
//   only while the block is idle, as the block itself does not enforce it.
//   An accepted event is matched against all scanned slots at once and
//   parked in a pending register together with its match mask. Each cycle
//   the output register is free, the single scaler shared by the slots
//   scales the lowest pending slot into it, so the rate is one result per
//   cycle while cc_out does not stall. An event holds the pending register
//   until its last match is issued; the next event is taken in the cycle
//   its last result is issued. Events that match nothing are dropped on
//   accept; results go through the pending and then the output register.
//   When cc_out stalls, the output register holds its transaction and the
//   pending register waits; cc_in.ready drops until the pending run drains.
//   Reset (rst, synchronous) empties both registers and restores the slot
//   defaults: disabled, any channel, controller s, output channel s+1,
//   output controller 20+s, range 0..127.
// ----------------------------------------------------------------------------
module controller_remap_scaler #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [crs_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [crs_pkg::CfgDataWidth-1:0]     cfg_data,
  crs_in_if.sink                               cc_in,
  crs_out_if.source                            cc_out
);

  // Slot registers: all stored slots keep their contents; only the first
  // SLOT_COUNT are scanned.
  crs_pkg::slot_t slot_cfg [crs_pkg::SlotStore];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < crs_pkg::SlotStore; i++) begin
        slot_cfg[i] <= crs_pkg::slot_reset(crs_pkg::CfgIndexWidth'(i));
      end
    end else if (cfg_write) begin
      slot_cfg[cfg_index] <= crs_pkg::slot_t'(cfg_data);
    end
  end

  // ---------------------------------------------------------------------
  // Match stage: compare the incoming event against every scanned slot.
  // ---------------------------------------------------------------------
  logic [SLOT_COUNT-1:0] match_mask;

  always_comb begin
    logic [crs_pkg::ChannelWidth-1:0] chan_clamped;
    match_mask = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      // Clamp out-of-range input channels to the top channel.
      chan_clamped = (slot_cfg[i].in_chan > crs_pkg::ChannelMax) ?
                     crs_pkg::ChannelMax : slot_cfg[i].in_chan;
      match_mask[i] = slot_cfg[i].enable
                   && (slot_cfg[i].in_cc == cc_in.in_controller)
                   && ((chan_clamped == '0) || (chan_clamped == cc_in.in_channel));
    end
  end

  // ---------------------------------------------------------------------
  // Pending register: event payload plus slots still to be issued.
  // ---------------------------------------------------------------------
  logic [SLOT_COUNT-1:0]               pend_mask;
  logic [crs_pkg::ValueWidth-1:0]      pend_value;
  logic [crs_pkg::OffsetWidth-1:0]     pend_offset;

  logic pend_valid;
  logic out_free;
  logic issue;
  logic issue_last;
  logic in_take;

  // Lowest pending slot and the mask left after issuing it.
  logic [crs_pkg::SlotIdxWidth-1:0] sel_idx;
  logic [SLOT_COUNT-1:0]            sel_onehot;
  logic [SLOT_COUNT-1:0]            mask_next;

  always_comb begin
    sel_idx    = '0;
    sel_onehot = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (pend_mask[i]) begin
        sel_idx    = crs_pkg::SlotIdxWidth'(i);
        sel_onehot = SLOT_COUNT'(1) << i;
      end
    end
    mask_next = pend_mask & ~sel_onehot;
  end

  assign pend_valid   = |pend_mask;
  assign out_free     = !cc_out.valid || cc_out.ready;
  assign issue        = pend_valid && out_free;
  assign issue_last   = issue && (mask_next == '0);
  assign cc_in.ready  = !pend_valid || issue_last;
  assign in_take      = cc_in.valid && cc_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_mask <= '0;
    end else if (in_take) begin
      // An event with no match loads an empty mask and is dropped here.
      pend_mask <= match_mask;
    end else if (issue) begin
      pend_mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pend_value  <= cc_in.in_value;
      pend_offset <= cc_in.in_sample_offset;
    end
  end

  // ---------------------------------------------------------------------
  // Scaler: min + round(span * value / 127), mirrored when min > max.
  // The divide by 127 splits num = a*128 + b = a*127 + (a + b); since
  // a + b stays below 254, one compare finishes the quotient.
  // ---------------------------------------------------------------------
  crs_pkg::slot_t                  sel_slot;
  logic                            ascending;
  logic [crs_pkg::ValueWidth-1:0]  span;
  logic [2*crs_pkg::ValueWidth-1:0] num;
  logic [crs_pkg::ValueWidth-1:0]  num_hi;
  logic [crs_pkg::ValueWidth-1:0]  num_lo;
  logic [crs_pkg::ValueWidth:0]    rem_sum;
  logic [crs_pkg::ValueWidth-1:0]  quot;
  logic [crs_pkg::ValueWidth-1:0]  scaled;

  assign sel_slot  = slot_cfg[sel_idx];
  assign ascending = sel_slot.min_val <= sel_slot.max_val;
  assign span      = ascending ? (sel_slot.max_val - sel_slot.min_val)
                               : (sel_slot.min_val - sel_slot.max_val);
  assign num       = ((2*crs_pkg::ValueWidth)'(span) * (2*crs_pkg::ValueWidth)'(pend_value))
                   + (2*crs_pkg::ValueWidth)'(crs_pkg::RoundBias);
  assign num_hi    = num[2*crs_pkg::ValueWidth-1:crs_pkg::ValueWidth];
  assign num_lo    = num[crs_pkg::ValueWidth-1:0];
  assign rem_sum   = (crs_pkg::ValueWidth+1)'(num_hi) + (crs_pkg::ValueWidth+1)'(num_lo);
  assign quot      = num_hi + crs_pkg::ValueWidth'(rem_sum >= crs_pkg::ScaleDiv);
  assign scaled    = ascending ? (sel_slot.min_val + quot) : (sel_slot.min_val - quot);

  // ---------------------------------------------------------------------
  // Output register: load on issue, drop once the sink takes it.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cc_out.valid <= 1'b0;
    end else if (issue) begin
      cc_out.valid <= 1'b1;
    end else if (cc_out.ready) begin
      cc_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cc_out.out_channel       <= crs_pkg::ChannelWidth'(sel_slot.out_chan) + 1'b1;
      cc_out.out_controller    <= sel_slot.out_cc;
      cc_out.out_value         <= scaled;
      cc_out.out_sample_offset <= pend_offset;
      cc_out.slot_index        <= sel_idx;
      cc_out.last_of_run       <= issue_last;
    end
  end

endmodule
